[hdl/vmbrf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vmbrf_pkg
// Shared types, register offsets and constants of the virtio-mmio block
// device register front end.
// ----------------------------------------------------------------------------
package vmbrf_pkg;

   // Width of the decoded part of the register offset
   localparam int OFS_W = 9;

   // Request kinds
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_DONE  = 2'd2
   } op_type;

   // Configuration port register indexes
   typedef enum logic [1:0] {
      CSR_BASE     = 2'd0,
      CSR_FEATURES = 2'd1,
      CSR_CAPACITY = 2'd2,
      CSR_GEN      = 2'd3
   } csr_idx_type;

   // Identification words
   localparam logic [31:0] MAGIC_WORD     = 32'h7472_6976;
   localparam logic [31:0] VERSION_WORD   = 32'h0000_0002;
   localparam logic [31:0] DEVICE_ID_WORD = 32'h0000_0002;
   localparam logic [31:0] VENDOR_WORD    = 32'h4d45_5652;
   localparam logic [31:0] MAX_QUEUE_SIZE = 32'd128;
   localparam logic [31:0] SEGMENT_LIMIT  = 32'd128;
   localparam logic [31:0] WORD_MASK      = 32'hFFFF_FFFF;

   localparam logic [63:0] FEATURES_RESET = 64'h0000_0001_0000_0046;

   // Register window offsets
   localparam logic [OFS_W-1:0] OFS_MAGIC      = 9'h000;
   localparam logic [OFS_W-1:0] OFS_VERSION    = 9'h004;
   localparam logic [OFS_W-1:0] OFS_DEVICE_ID  = 9'h008;
   localparam logic [OFS_W-1:0] OFS_VENDOR     = 9'h00c;
   localparam logic [OFS_W-1:0] OFS_DEV_FEAT   = 9'h010;
   localparam logic [OFS_W-1:0] OFS_FEAT_SEL   = 9'h014;
   localparam logic [OFS_W-1:0] OFS_QUEUE_SEL  = 9'h030;
   localparam logic [OFS_W-1:0] OFS_QUEUE_MAX  = 9'h034;
   localparam logic [OFS_W-1:0] OFS_QUEUE_NUM  = 9'h038;
   localparam logic [OFS_W-1:0] OFS_QUEUE_RDY  = 9'h044;
   localparam logic [OFS_W-1:0] OFS_NOTIFY     = 9'h050;
   localparam logic [OFS_W-1:0] OFS_IRQ_STAT   = 9'h060;
   localparam logic [OFS_W-1:0] OFS_IRQ_ACK    = 9'h064;
   localparam logic [OFS_W-1:0] OFS_STATUS     = 9'h070;
   localparam logic [OFS_W-1:0] OFS_DESC_LO    = 9'h080;
   localparam logic [OFS_W-1:0] OFS_DESC_HI    = 9'h084;
   localparam logic [OFS_W-1:0] OFS_DRV_LO     = 9'h090;
   localparam logic [OFS_W-1:0] OFS_DRV_HI     = 9'h094;
   localparam logic [OFS_W-1:0] OFS_DEVR_LO    = 9'h0a0;
   localparam logic [OFS_W-1:0] OFS_DEVR_HI    = 9'h0a4;
   localparam logic [OFS_W-1:0] OFS_GENERATION = 9'h0fc;
   localparam logic [OFS_W-1:0] OFS_CAP_LO     = 9'h100;
   localparam logic [OFS_W-1:0] OFS_CAP_HI     = 9'h104;
   localparam logic [OFS_W-1:0] OFS_SIZE_MAX   = 9'h108;
   localparam logic [OFS_W-1:0] OFS_SEG_MAX    = 9'h10c;

   // Configuration register set
   typedef struct packed {
      logic [63:0] base_address;
      logic [63:0] offered_features;
      logic [63:0] capacity_in_sectors;
      logic [31:0] generation_count;
   } cfg_type;

   // One request after offset translation
   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] offset;
      logic [31:0] write_value;
   } req_type;

   // One response
   typedef struct packed {
      logic [31:0] read_value;
      logic        queue_start;
      logic        irq_pending;
   } rsp_type;

endpackage
`default_nettype wire

[hdl/vmbrf_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vmbrf_csr
// APB configuration registers: window base, offered features, capacity and
// configuration generation.
// ----------------------------------------------------------------------------
module vmbrf_csr (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [63:0]        csr_pwdata,
   output logic      [63:0]        csr_prdata,
   output logic                    csr_pready,
   output vmbrf_pkg::cfg_type      cfg
);
   import vmbrf_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign idx        = csr_idx_type'(csr_paddr[4:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Decode write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            CSR_BASE:     cfg_in.base_address        = csr_pwdata;
            CSR_FEATURES: cfg_in.offered_features    = csr_pwdata;
            CSR_CAPACITY: cfg_in.capacity_in_sectors = csr_pwdata;
            CSR_GEN:      cfg_in.generation_count    = csr_pwdata[31:0] & WORD_MASK;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (idx)
         CSR_BASE:     csr_prdata = cfg_ff.base_address;
         CSR_FEATURES: csr_prdata = cfg_ff.offered_features;
         CSR_CAPACITY: csr_prdata = cfg_ff.capacity_in_sectors;
         CSR_GEN:      csr_prdata = {32'd0, cfg_ff.generation_count};
         default:      csr_prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address        <= 64'd0;
         cfg_ff.offered_features    <= FEATURES_RESET;
         cfg_ff.capacity_in_sectors <= 64'd0;
         cfg_ff.generation_count    <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

[hdl/vmbrf_dev.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vmbrf_dev
// Device register state of queue 0 with read mux and write decode; builds
// the response of one request and updates state when the request is taken.
// ----------------------------------------------------------------------------
module vmbrf_dev (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire vmbrf_pkg::cfg_type cfg,
   input  wire vmbrf_pkg::req_type item,
   input  wire logic               fire,
   output vmbrf_pkg::rsp_type      result
);
   import vmbrf_pkg::*;

   logic [31:0] feature_select_ff, feature_select_in;
   logic [31:0] queue_select_ff,   queue_select_in;
   logic [31:0] queue_length_ff,   queue_length_in;
   logic        queue_enabled_ff,  queue_enabled_in;
   logic [63:0] dtab_addr_ff,      dtab_addr_in;
   logic [63:0] drv_addr_ff,       drv_addr_in;
   logic [63:0] devr_addr_ff,      devr_addr_in;
   logic [31:0] irq_bits_ff,       irq_bits_in;
   logic [31:0] status_ff,         status_in;

   logic             hit;
   logic [OFS_W-1:0] ofs;
   logic [31:0]      wv;
   logic             q0;
   logic [31:0]      rd_mux;
   logic             start;

   assign hit = (item.offset[63:OFS_W] == '0);
   assign ofs = item.offset[OFS_W-1:0];
   assign wv  = item.write_value;
   assign q0  = (queue_select_ff == 32'd0);

   // Read mux over the register window
   always_comb begin
      unique case (ofs)
         OFS_MAGIC:      rd_mux = MAGIC_WORD;
         OFS_VERSION:    rd_mux = VERSION_WORD;
         OFS_DEVICE_ID:  rd_mux = DEVICE_ID_WORD;
         OFS_VENDOR:     rd_mux = VENDOR_WORD;
         OFS_DEV_FEAT:   rd_mux = (feature_select_ff == 32'd0) ?
                                  cfg.offered_features[31:0] : cfg.offered_features[63:32];
         OFS_FEAT_SEL:   rd_mux = feature_select_ff;
         OFS_QUEUE_SEL:  rd_mux = queue_select_ff;
         OFS_QUEUE_MAX:  rd_mux = q0 ? MAX_QUEUE_SIZE : 32'd0;
         OFS_QUEUE_NUM:  rd_mux = queue_length_ff;
         OFS_QUEUE_RDY:  rd_mux = {31'd0, queue_enabled_ff};
         OFS_IRQ_STAT:   rd_mux = irq_bits_ff;
         OFS_STATUS:     rd_mux = status_ff;
         OFS_DESC_LO:    rd_mux = dtab_addr_ff[31:0];
         OFS_DESC_HI:    rd_mux = dtab_addr_ff[63:32];
         OFS_DRV_LO:     rd_mux = drv_addr_ff[31:0];
         OFS_DRV_HI:     rd_mux = drv_addr_ff[63:32];
         OFS_DEVR_LO:    rd_mux = devr_addr_ff[31:0];
         OFS_DEVR_HI:    rd_mux = devr_addr_ff[63:32];
         OFS_GENERATION: rd_mux = cfg.generation_count;
         OFS_CAP_LO:     rd_mux = cfg.capacity_in_sectors[31:0];
         OFS_CAP_HI:     rd_mux = cfg.capacity_in_sectors[63:32];
         OFS_SIZE_MAX:   rd_mux = 32'd0;
         OFS_SEG_MAX:    rd_mux = SEGMENT_LIMIT;
         default:        rd_mux = 32'd0;
      endcase
   end

   // Apply writes and completion events
   always_comb begin
      feature_select_in = feature_select_ff;
      queue_select_in   = queue_select_ff;
      queue_length_in   = queue_length_ff;
      queue_enabled_in  = queue_enabled_ff;
      dtab_addr_in      = dtab_addr_ff;
      drv_addr_in       = drv_addr_ff;
      devr_addr_in      = devr_addr_ff;
      irq_bits_in       = irq_bits_ff;
      status_in         = status_ff;
      start             = 1'b0;

      if (item.opcode == OP_WRITE && hit) begin
         unique case (ofs)
            OFS_FEAT_SEL:  feature_select_in = wv;
            OFS_QUEUE_SEL: queue_select_in   = wv;
            OFS_QUEUE_NUM: if (q0) queue_length_in  = wv;
            OFS_QUEUE_RDY: if (q0) queue_enabled_in = (wv != 32'd0);
            OFS_DESC_LO:   if (q0) dtab_addr_in = {dtab_addr_ff[63:32], wv};
            OFS_DESC_HI:   if (q0) dtab_addr_in = {wv, dtab_addr_ff[31:0]};
            OFS_DRV_LO:    if (q0) drv_addr_in  = {drv_addr_ff[63:32], wv};
            OFS_DRV_HI:    if (q0) drv_addr_in  = {wv, drv_addr_ff[31:0]};
            OFS_DEVR_LO:   if (q0) devr_addr_in = {devr_addr_ff[63:32], wv};
            OFS_DEVR_HI:   if (q0) devr_addr_in = {wv, devr_addr_ff[31:0]};
            OFS_NOTIFY:    start = (wv == 32'd0) && queue_enabled_ff &&
                                   (queue_length_ff != 32'd0);
            OFS_IRQ_ACK:   irq_bits_in = irq_bits_ff & ~wv;
            OFS_STATUS: begin
               if (wv == 32'd0) begin
                  // Device reset keeps the selectors
                  status_in        = 32'd0;
                  irq_bits_in      = 32'd0;
                  queue_enabled_in = 1'b0;
                  queue_length_in  = 32'd0;
                  dtab_addr_in     = 64'd0;
                  drv_addr_in      = 64'd0;
                  devr_addr_in     = 64'd0;
               end else begin
                  status_in = status_ff | wv;
               end
            end
            default: ;
         endcase
      end else if (item.opcode == OP_DONE) begin
         irq_bits_in = irq_bits_ff | 32'd1;
      end
   end

   // Response of the current request
   always_comb begin
      result.read_value  = (item.opcode == OP_READ && hit) ? rd_mux : 32'd0;
      result.queue_start = start;
      result.irq_pending = (irq_bits_in != 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feature_select_ff <= 32'd0;
         queue_select_ff   <= 32'd0;
         queue_length_ff   <= 32'd0;
         queue_enabled_ff  <= 1'b0;
         dtab_addr_ff      <= 64'd0;
         drv_addr_ff       <= 64'd0;
         devr_addr_ff      <= 64'd0;
         irq_bits_ff       <= 32'd0;
         status_ff         <= 32'd0;
      end else if (fire) begin
         feature_select_ff <= feature_select_in;
         queue_select_ff   <= queue_select_in;
         queue_length_ff   <= queue_length_in;
         queue_enabled_ff  <= queue_enabled_in;
         dtab_addr_ff      <= dtab_addr_in;
         drv_addr_ff       <= drv_addr_in;
         devr_addr_ff      <= devr_addr_in;
         irq_bits_ff       <= irq_bits_in;
         status_ff         <= status_in;
      end
   end

endmodule
`default_nettype wire

[hdl/virtio_mmio_block_register_file.sv]
`default_nettype none
// A request is captured in the input stage register; its response then moves
// into the response register, which offers it until it is taken.
// Throughput: one request per cycle unless responses stall; the response register
// decouples the sides, so an empty input stage takes a request while one waits.
// Reset: synchronous; clears both stage valids, all device state, and loads
// the configuration registers with their reset values.
// ----------------------------------------------------------------------------
// virtio_mmio_block_register_file
// Register front end of a virtio-mmio version 2 block device: request
// stream in, response stream out, APB configuration port.
// ----------------------------------------------------------------------------
module virtio_mmio_block_register_file (
   input  wire logic         clock,
   input  wire logic         reset,
   // request
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // bus_address[63:0], write_value[95:64]
   input  wire logic [1:0]   req_tuser,   // opcode[1:0]
   // response
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [39:0]  rsp_tdata,   // read_value[31:0], queue_start[32],
                                          // irq_pending[33], zero[39:34]
   // configuration
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [4:0]   csr_paddr,
   input  wire logic [63:0]  csr_pwdata,
   output logic      [63:0]  csr_prdata,
   output logic              csr_pready
);
   import vmbrf_pkg::*;

   cfg_type cfg;
   req_type req_item_ff, req_item_in;
   logic    req_valid_ff, req_valid_in;
   rsp_type rsp_item_ff, result;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    req_take;
   logic    adv;

   vmbrf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   vmbrf_dev u_dev (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (req_item_ff),
      .fire   (adv),
      .result (result)
   );

   // Advance the input stage when the response register is free or drains
   assign adv        = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || adv;
   assign req_take   = req_tvalid && req_tready;

   // Translate the bus address into a window offset on capture
   always_comb begin
      req_item_in.opcode      = req_tuser;
      req_item_in.offset      = req_tdata[63:0] - cfg.base_address;
      req_item_in.write_value = req_tdata[95:64];
      req_valid_in            = req_tready ? req_tvalid : req_valid_ff;
      rsp_valid_in            = adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff <= req_item_in;
      end
      if (adv) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_item_ff.irq_pending, rsp_item_ff.queue_start,
                        rsp_item_ff.read_value};

   // Full pipeline with a stalled response must hold off new requests
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipeline is full and stalled");

   // An accepted request occupies the input stage next cycle
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_valid_ff)
      else $error("accepted request lost from input stage");

   // A start pulse comes only with a zero read value
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (adv && result.queue_start) |=> (rsp_tvalid && rsp_tdata[31:0] == 32'd0))
      else $error("start pulse carries read data");

   // Nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule
`default_nettype wire

[dv/vmbrf_regfile_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vmbrf_regfile_checker
// Watches the request, response and configuration ports of the virtio-mmio
// register front end. It keeps its own copy of the device registers, works
// out the response of every accepted request, and compares each accepted
// response field by field against the oldest one still awaited.
// ----------------------------------------------------------------------------
module vmbrf_regfile_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,   // bus_address[63:0], write_value[95:64]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,   // read_value[31:0], queue_start[32],
                                         // irq_pending[33], zero[39:34]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [63:0] csr_pwdata,
   output int               fail_count,
   output int               rsp_pending
);
   import vmbrf_pkg::*;

   // Configuration copy
   logic [63:0] base_addr;
   logic [63:0] dev_features;
   logic [63:0] capacity;
   logic [31:0] gen_count;

   // Device register copy
   logic [31:0] feat_sel;
   logic [31:0] q_select;
   logic [31:0] queue_len;
   logic        queue_ready;
   logic [63:0] dtab_addr;
   logic [63:0] drv_ring_addr;
   logic [63:0] dev_ring_addr;
   logic [31:0] irq_bits;
   logic [31:0] dev_status;

   rsp_type awaited_rsps [$];
   int      errs = 0;

   // Apply one request to the register copy and return its response
   function automatic rsp_type regfile_access(input logic [1:0] op,
                                              input logic [63:0] addr,
                                              input logic [31:0] wv);
      rsp_type          r;
      logic [63:0]      ofs;
      logic [OFS_W-1:0] lo;
      logic             in_window;
      logic             sel0;
      r         = '0;
      ofs       = addr - base_addr;
      lo        = ofs[OFS_W-1:0];
      in_window = (ofs[63:OFS_W] == '0);
      sel0      = (q_select == '0);
      case (op)
         OP_READ: if (in_window) begin
            case (lo)
               OFS_MAGIC:      r.read_value = MAGIC_WORD;
               OFS_VERSION:    r.read_value = VERSION_WORD;
               OFS_DEVICE_ID:  r.read_value = DEVICE_ID_WORD;
               OFS_VENDOR:     r.read_value = VENDOR_WORD;
               OFS_DEV_FEAT:   r.read_value = (feat_sel == '0) ? dev_features[31:0]
                                                               : dev_features[63:32];
               OFS_FEAT_SEL:   r.read_value = feat_sel;
               OFS_QUEUE_SEL:  r.read_value = q_select;
               OFS_QUEUE_MAX:  r.read_value = sel0 ? MAX_QUEUE_SIZE : '0;
               OFS_QUEUE_NUM:  r.read_value = queue_len;
               OFS_QUEUE_RDY:  r.read_value = {31'd0, queue_ready};
               OFS_IRQ_STAT:   r.read_value = irq_bits;
               OFS_STATUS:     r.read_value = dev_status;
               OFS_DESC_LO:    r.read_value = dtab_addr[31:0];
               OFS_DESC_HI:    r.read_value = dtab_addr[63:32];
               OFS_DRV_LO:     r.read_value = drv_ring_addr[31:0];
               OFS_DRV_HI:     r.read_value = drv_ring_addr[63:32];
               OFS_DEVR_LO:    r.read_value = dev_ring_addr[31:0];
               OFS_DEVR_HI:    r.read_value = dev_ring_addr[63:32];
               OFS_GENERATION: r.read_value = gen_count;
               OFS_CAP_LO:     r.read_value = capacity[31:0];
               OFS_CAP_HI:     r.read_value = capacity[63:32];
               OFS_SIZE_MAX:   r.read_value = '0;
               OFS_SEG_MAX:    r.read_value = SEGMENT_LIMIT;
               default:        r.read_value = '0;
            endcase
         end
         OP_WRITE: if (in_window) begin
            case (lo)
               OFS_FEAT_SEL:  feat_sel  = wv;
               OFS_QUEUE_SEL: q_select  = wv;
               OFS_QUEUE_NUM: if (sel0) queue_len = wv;
               OFS_QUEUE_RDY: if (sel0) queue_ready = (wv != '0);
               OFS_DESC_LO:   if (sel0) dtab_addr[31:0]      = wv;
               OFS_DESC_HI:   if (sel0) dtab_addr[63:32]     = wv;
               OFS_DRV_LO:    if (sel0) drv_ring_addr[31:0]  = wv;
               OFS_DRV_HI:    if (sel0) drv_ring_addr[63:32] = wv;
               OFS_DEVR_LO:   if (sel0) dev_ring_addr[31:0]  = wv;
               OFS_DEVR_HI:   if (sel0) dev_ring_addr[63:32] = wv;
               OFS_NOTIFY:    r.queue_start = (wv == '0) && queue_ready && (queue_len != '0);
               OFS_IRQ_ACK:   irq_bits = irq_bits & ~wv;
               OFS_STATUS: begin
                  // a zero status write resets the device, selectors survive
                  if (wv == '0) begin
                     dev_status    = '0;
                     irq_bits      = '0;
                     queue_ready   = 1'b0;
                     queue_len     = '0;
                     dtab_addr     = '0;
                     drv_ring_addr = '0;
                     dev_ring_addr = '0;
                  end else begin
                     dev_status = dev_status | wv;
                  end
               end
               default: ;
            endcase
         end
         OP_DONE: irq_bits[0] = 1'b1;
         default: ;
      endcase
      r.irq_pending = (irq_bits != '0);
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
         errs++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         base_addr     = '0;
         dev_features  = FEATURES_RESET;
         capacity      = '0;
         gen_count     = '0;
         feat_sel      = '0;
         q_select      = '0;
         queue_len     = '0;
         queue_ready   = 1'b0;
         dtab_addr     = '0;
         drv_ring_addr = '0;
         dev_ring_addr = '0;
         irq_bits      = '0;
         dev_status    = '0;
         awaited_rsps.delete();
      end else begin
         // track configuration writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2:0] == 3'b000) begin
            case (csr_idx_type'(csr_paddr[4:3]))
               CSR_BASE:     base_addr    = csr_pwdata;
               CSR_FEATURES: dev_features = csr_pwdata;
               CSR_CAPACITY: capacity     = csr_pwdata;
               CSR_GEN:      gen_count    = csr_pwdata[31:0] & WORD_MASK;
               default: ;
            endcase
         end
         // compare the response against the oldest awaited one
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsps.size() == 0) begin
               $display("%0t: response with none awaited, expected nothing got %h",
                        $time, rsp_tdata);
               errs++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("read_value", want.read_value, rsp_tdata[31:0]);
               check_field("queue_start", {31'd0, want.queue_start}, {31'd0, rsp_tdata[32]});
               check_field("irq_pending", {31'd0, want.irq_pending}, {31'd0, rsp_tdata[33]});
               check_field("padding", 32'd0, {26'd0, rsp_tdata[39:34]});
            end
         end
         // predict the response of an accepted request
         if (req_tvalid && req_tready)
            awaited_rsps.insert(awaited_rsps.size(),
                                regfile_access(req_tuser, req_tdata[63:0],
                                               req_tdata[95:64]));
      end
      fail_count  <= errs;
      rsp_pending <= awaited_rsps.size();
   end

endmodule

[dv/tb_virtio_mmio_block_register_file.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_virtio_mmio_block_register_file
// Drives register reads, writes and completion events into the virtio-mmio
// register front end under several configuration settings, with random
// gaps and back pressure, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_virtio_mmio_block_register_file;
   import vmbrf_pkg::*;

   // Opcode with no effect, outside the package set
   localparam logic [1:0] OP_NOP = 2'd3;

   // Driver feature latch, write only
   localparam logic [OFS_W-1:0] OFS_DRV_FEAT     = 9'h020;
   localparam logic [OFS_W-1:0] OFS_DRV_FEAT_SEL = 9'h024;

   // Device status bits used in bring-up
   localparam logic [31:0] ST_ACK         = 32'h0000_0001;
   localparam logic [31:0] ST_DRIVER      = 32'h0000_0002;
   localparam logic [31:0] ST_DRIVER_OK   = 32'h0000_0004;
   localparam logic [31:0] ST_FEATURES_OK = 32'h0000_0008;

   localparam int N_OFS       = 27;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 305;

   typedef enum logic [1:0] {
      SINK_RANDOM,
      SINK_STEADY,
      SINK_HOLD
   } sink_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;   // bus_address[63:0], write_value[95:64]
   logic [1:0]  req_tuser;   // opcode[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // read_value[31:0], queue_start[32], irq_pending[33],
                             // zero[39:34]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int            fail_count;
   int            rsp_pending;
   sink_mode_type sink_mode = SINK_RANDOM;
   bit            src_steady = 1'b0;
   logic [63:0]   cur_base = '0;
   int            items_sent = 0;
   int            seq_skip = 0;

   logic [OFS_W-1:0] reg_offsets [0:N_OFS-1] = '{
      OFS_MAGIC, OFS_VERSION, OFS_DEVICE_ID, OFS_VENDOR, OFS_DEV_FEAT, OFS_FEAT_SEL,
      OFS_DRV_FEAT, OFS_DRV_FEAT_SEL, OFS_QUEUE_SEL, OFS_QUEUE_MAX, OFS_QUEUE_NUM,
      OFS_QUEUE_RDY, OFS_NOTIFY, OFS_IRQ_STAT, OFS_IRQ_ACK, OFS_STATUS, OFS_DESC_LO,
      OFS_DESC_HI, OFS_DRV_LO, OFS_DRV_HI, OFS_DEVR_LO, OFS_DEVR_HI, OFS_GENERATION,
      OFS_CAP_LO, OFS_CAP_HI, OFS_SIZE_MAX, OFS_SEG_MAX
   };

   virtio_mmio_block_register_file u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   vmbrf_regfile_checker u_regfile_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .rsp_pending (rsp_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Response side: random stalls, steady stretches, one long hold-off
   initial begin : rsp_sink
      int held;
      held = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_mode == SINK_HOLD && held < HOLD_CYCLES) begin
            held++;
            rsp_tready <= 1'b0;
         end else begin
            if (sink_mode != SINK_HOLD)
               held = 0;
            rsp_tready <= (sink_mode != SINK_RANDOM) || ($urandom_range(99) >= 23);
         end
      end
   end

   // Offer one request and hold it until accepted; valid stays high afterwards
   task automatic send_req(input logic [1:0] op, input logic [63:0] addr,
                           input logic [31:0] wv);
      while (!src_steady && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {wv, addr};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_reg(input logic [1:0] op, input logic [OFS_W-1:0] ofs,
                           input logic [31:0] wv);
      send_req(op, cur_base + 64'(ofs), wv);
   endtask

   // Drop valid and wait until every awaited response has arrived
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rsp_pending != 0) @(posedge clock);
   endtask

   // APB write: setup cycle and access cycle, then back to idle
   task automatic csr_write(input csr_idx_type idx, input logic [63:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bit keep_step();
      return $urandom_range(99) >= seq_skip;
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 35)      return '0;
      else if (r < 50) return 32'($urandom_range(1, 3));
      else if (r < 60) return '1;
      else             return $urandom;
   endfunction

   // Driver bring-up of queue 0, then notify / complete / acknowledge rounds;
   // some sequences drop steps at random
   task automatic bringup_queue();
      logic [31:0] qlen;
      int          rounds;
      int          r;
      seq_skip = ($urandom_range(99) < 25) ? 20 : 0;
      r = $urandom_range(99);
      if (r < 10)      qlen = '0;
      else if (r < 20) qlen = $urandom;
      else             qlen = 32'($urandom_range(1, 128));
      rounds = $urandom_range(1, 4);
      if (keep_step()) send_reg(OP_WRITE, OFS_STATUS, 32'd0);
      if (keep_step()) send_reg(OP_WRITE, OFS_STATUS, ST_ACK);
      if (keep_step()) send_reg(OP_WRITE, OFS_STATUS, ST_DRIVER);
      if (keep_step()) send_reg(OP_WRITE, OFS_FEAT_SEL, 32'($urandom_range(1)));
      if (keep_step()) send_reg(OP_READ, OFS_DEV_FEAT, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_DRV_FEAT, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_STATUS, ST_FEATURES_OK);
      if (keep_step()) send_reg(OP_WRITE, OFS_QUEUE_SEL, 32'd0);
      if (keep_step()) send_reg(OP_READ, OFS_QUEUE_MAX, 32'd0);
      if (keep_step()) send_reg(OP_WRITE, OFS_QUEUE_NUM, qlen);
      if (keep_step()) send_reg(OP_WRITE, OFS_DESC_LO, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_DESC_HI, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_DRV_LO, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_DRV_HI, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_DEVR_LO, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_DEVR_HI, $urandom);
      if (keep_step()) send_reg(OP_WRITE, OFS_QUEUE_RDY, 32'd1);
      if (keep_step()) send_reg(OP_WRITE, OFS_STATUS, ST_DRIVER_OK);
      repeat (rounds) begin
         if (keep_step()) send_reg(OP_WRITE, OFS_NOTIFY, 32'd0);
         if (keep_step()) send_req(OP_DONE, {$urandom, $urandom}, $urandom);
         if (keep_step()) send_reg(OP_READ, OFS_IRQ_STAT, $urandom);
         if (keep_step()) send_reg(OP_WRITE, OFS_IRQ_ACK, 32'd1);
      end
      if (keep_step()) send_reg(OP_READ, reg_offsets[$urandom_range(N_OFS - 1)], $urandom);
   endtask

   // One loose request: any opcode, mostly mapped offsets
   task automatic random_access();
      logic [1:0]  op;
      logic [63:0] addr;
      int          r;
      r = $urandom_range(99);
      if (r < 45)      op = OP_READ;
      else if (r < 85) op = OP_WRITE;
      else if (r < 95) op = OP_DONE;
      else             op = OP_NOP;
      r = $urandom_range(99);
      if (r < 72)
         addr = cur_base + 64'(reg_offsets[$urandom_range(N_OFS - 1)]);
      else if (r < 86)
         addr = cur_base + 64'($urandom_range(511));
      else if (r < 93)
         addr = {$urandom, $urandom};
      else
         addr = cur_base + ({$urandom, $urandom} & ~64'h1ff)
                + 64'(reg_offsets[$urandom_range(N_OFS - 1)]);
      send_req(op, addr, pick_value());
   endtask

   initial begin : stimulus
      int  ph;
      int  target;
      bit  hold_done;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: identification, selectors, notify rules, interrupts, reset
      send_reg(OP_READ,  OFS_MAGIC, 32'd0);
      send_reg(OP_READ,  OFS_VENDOR, 32'd0);
      send_reg(OP_READ,  OFS_DEV_FEAT, 32'd0);
      send_reg(OP_WRITE, OFS_FEAT_SEL, 32'd1);
      send_reg(OP_READ,  OFS_DEV_FEAT, 32'd0);
      send_reg(OP_WRITE, OFS_QUEUE_SEL, 32'hFFFF_FFFF);
      send_reg(OP_WRITE, OFS_QUEUE_NUM, 32'd5);
      send_reg(OP_READ,  OFS_QUEUE_MAX, 32'd0);
      send_reg(OP_READ,  OFS_QUEUE_NUM, 32'd0);
      send_reg(OP_WRITE, OFS_QUEUE_SEL, 32'd0);
      send_reg(OP_WRITE, OFS_QUEUE_NUM, 32'hFFFF_FFFF);
      send_reg(OP_WRITE, OFS_NOTIFY, 32'd0);
      send_reg(OP_WRITE, OFS_QUEUE_RDY, 32'd1);
      send_reg(OP_WRITE, OFS_NOTIFY, 32'd0);
      send_reg(OP_WRITE, OFS_NOTIFY, 32'd1);
      send_reg(OP_DONE,  OFS_MAGIC, 32'hFFFF_FFFF);
      send_reg(OP_WRITE, OFS_IRQ_ACK, 32'hFFFF_FFFE);
      send_reg(OP_WRITE, OFS_IRQ_ACK, 32'hFFFF_FFFF);
      send_reg(OP_WRITE, OFS_STATUS, 32'h8000_0001);
      send_reg(OP_WRITE, OFS_DRV_FEAT, 32'hFFFF_FFFF);
      send_reg(OP_WRITE, OFS_STATUS, 32'd0);
      send_reg(OP_READ,  OFS_QUEUE_RDY, 32'd0);
      send_reg(OP_READ,  OFS_VENDOR + 9'd2, 32'd0);
      send_reg(OP_NOP,   OFS_MAGIC, 32'hFFFF_FFFF);
      send_req(OP_READ,  64'hFFFF_FFFF_FFFF_FFFC, 32'd0);
      send_reg(OP_READ,  OFS_SEG_MAX, 32'd0);
      send_reg(OP_READ,  OFS_CAP_HI, 32'd0);

      for (ph = 0; ph < 5; ph++) begin
         // reprogram only with the block idle
         wait_drain();
         case (ph)
            0: csr_write(CSR_GEN, {$urandom, $urandom});
            1: begin
               cur_base = 64'hFFFF_FFFF_FFFF_FF00;
               csr_write(CSR_BASE, cur_base);
               csr_write(CSR_FEATURES, '1);
               csr_write(CSR_CAPACITY, '1);
               csr_write(CSR_GEN, 64'hFFFF_FFFF);
            end
            2: begin
               cur_base = '0;
               csr_write(CSR_BASE, cur_base);
               csr_write(CSR_FEATURES, '0);
               csr_write(CSR_CAPACITY, '0);
               csr_write(CSR_GEN, '0);
            end
            default: begin
               cur_base = {$urandom, $urandom};
               csr_write(CSR_BASE, cur_base);
               csr_write(CSR_FEATURES, {$urandom, $urandom});
               csr_write(CSR_CAPACITY, {$urandom, $urandom});
               csr_write(CSR_GEN, {$urandom, $urandom});
            end
         endcase

         // phase 2 runs without gaps, phase 3 opens with a long hold-off
         src_steady = (ph == 2);
         if (ph == 2)      sink_mode <= SINK_STEADY;
         else if (ph == 3) sink_mode <= SINK_HOLD;
         else              sink_mode <= SINK_RANDOM;
         hold_done = (ph != 3);

         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if (!hold_done && items_sent >= target - PHASE_ITEMS + 40) begin
               sink_mode <= SINK_RANDOM;
               hold_done = 1'b1;
            end
            if ($urandom_range(99) < 45)
               bringup_queue();
            else
               random_access();
         end
      end

      wait_drain();
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
